[sv/dtp_pkg.sv]
// ----------------------------------------------------------------------------
// Decimal text parser package
// Shared types and constants for the decimal text to int32 parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

    // Byte offset saturation point and the width of the reported offset
    localparam int MAX_OFFSET = 4095;
    localparam int OFFSET_W   = 12;
    localparam int CNT_W      = $clog2(MAX_OFFSET + 1);

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Magnitude limits and the overflow threshold for a zero digit:
    // (limit - d) / 10 is this value, less one for the top digits.
    localparam logic [31:0] POS_LIMIT  = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT  = 32'h8000_0000;
    localparam logic [31:0] THRESH     = 32'd214748364;
    localparam logic [3:0]  RADIX      = 4'd10;
    localparam logic [3:0]  POS_TOP_D  = 4'd8;
    localparam logic [3:0]  NEG_TOP_D  = 4'd9;

    // Byte class as seen by the back end
    typedef enum logic [2:0] {
        KIND_SPACE,
        KIND_MINUS,
        KIND_PLUS,
        KIND_DIGIT,
        KIND_OTHER
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] digit;
    } tok_t;

endpackage

[sv/dtp_front.sv]
// ----------------------------------------------------------------------------
// Decimal text parser front end
// Accepts text bytes, classifies them and hands tokens to the queue.
// ----------------------------------------------------------------------------
module dtp_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_text_byte,
    output logic          push_valid,
    input  logic          push_ready,
    output dtp_pkg::tok_t push_tok
);

    logic          valid_reg;
    dtp_pkg::tok_t tok_reg;
    dtp_pkg::tok_t tok_next;
    logic [7:0]    digit_wide;

    // Classify the incoming byte
    always_comb begin
        digit_wide     = s_text_byte - dtp_pkg::CH_ZERO;
        tok_next.digit = digit_wide[3:0];
        if (s_text_byte == dtp_pkg::CH_SPACE || s_text_byte == dtp_pkg::CH_LF ||
            s_text_byte == dtp_pkg::CH_TAB || s_text_byte == dtp_pkg::CH_VT ||
            s_text_byte == dtp_pkg::CH_FF || s_text_byte == dtp_pkg::CH_CR) begin
            tok_next.kind = dtp_pkg::KIND_SPACE;
        end else if (s_text_byte == dtp_pkg::CH_MINUS) begin
            tok_next.kind = dtp_pkg::KIND_MINUS;
        end else if (s_text_byte == dtp_pkg::CH_PLUS) begin
            tok_next.kind = dtp_pkg::KIND_PLUS;
        end else if (s_text_byte >= dtp_pkg::CH_ZERO && s_text_byte <= dtp_pkg::CH_NINE) begin
            tok_next.kind = dtp_pkg::KIND_DIGIT;
        end else begin
            tok_next.kind = dtp_pkg::KIND_OTHER;
        end
    end

    // Stage register: refills whenever it is empty or draining
    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_tok   = tok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            tok_reg <= tok_next;
        end
    end

endmodule

[sv/dtp_queue.sv]
// ----------------------------------------------------------------------------
// Decimal text parser token queue
// Short register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module dtp_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  dtp_pkg::tok_t push_tok,
    output logic          pop_valid,
    input  logic          pop_ready,
    output dtp_pkg::tok_t pop_tok
);

    localparam int PTR_W  = (dtp_pkg::QUEUE_DEPTH > 1) ? $clog2(dtp_pkg::QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(dtp_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(dtp_pkg::QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL     = FILL_W'(dtp_pkg::QUEUE_DEPTH);

    dtp_pkg::tok_t     entries_reg [dtp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != FULL);
    assign pop_valid  = (fill_reg != '0);
    assign pop_tok    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

[sv/dtp_back.sv]
// ----------------------------------------------------------------------------
// Decimal text parser back end
// Runs the parse state over tokens and holds the result beat register.
// ----------------------------------------------------------------------------
module dtp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  dtp_pkg::tok_t                 pop_tok,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_parsed_value,
    output logic [dtp_pkg::OFFSET_W-1:0]  m_end_offset,
    output logic                          m_overflow_stop
);

    typedef enum logic {
        PH_SKIP,
        PH_DIGITS
    } phase_t;

    localparam logic [dtp_pkg::CNT_W-1:0] CNT_MAX = dtp_pkg::CNT_W'(dtp_pkg::MAX_OFFSET);

    phase_t                     phase_reg, phase_next;
    logic                       neg_reg, neg_next;
    logic [31:0]                mag_reg, mag_next;
    logic [dtp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [dtp_pkg::CNT_W-1:0]  cnt_inc;
    logic                       out_valid_reg;
    logic signed [31:0]         out_value_reg;
    logic [dtp_pkg::OFFSET_W-1:0] out_offset_reg;
    logic                       out_ovf_reg;
    logic [31:0]                thr;
    logic [31:0]                cnt_wide;
    logic                       take_digits;
    logic                       emit;
    logic                       ovf;
    logic                       do_pop;

    // Overflow threshold for this digit, saturating byte count
    always_comb begin
        thr      = dtp_pkg::THRESH - 32'(pop_tok.digit >=
                   (neg_reg ? dtp_pkg::NEG_TOP_D : dtp_pkg::POS_TOP_D));
        cnt_inc  = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        cnt_wide = 32'(cnt_reg);
    end

    // Parse step for the token at the head of the queue
    always_comb begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        cnt_next    = cnt_reg;
        take_digits = 1'b0;
        emit        = 1'b0;
        ovf         = 1'b0;
        if (phase_reg == PH_SKIP) begin
            case (pop_tok.kind)
                dtp_pkg::KIND_SPACE: begin
                    cnt_next = cnt_inc;
                end
                dtp_pkg::KIND_MINUS, dtp_pkg::KIND_PLUS: begin
                    neg_next   = (pop_tok.kind == dtp_pkg::KIND_MINUS);
                    phase_next = PH_DIGITS;
                    cnt_next   = cnt_inc;
                end
                default: begin
                    take_digits = 1'b1;
                end
            endcase
        end else begin
            take_digits = 1'b1;
        end
        if (take_digits) begin
            if (pop_tok.kind == dtp_pkg::KIND_DIGIT) begin
                if (mag_reg > thr) begin
                    emit = 1'b1;
                    ovf  = 1'b1;
                end else begin
                    mag_next   = mag_reg * 32'(dtp_pkg::RADIX) + 32'(pop_tok.digit);
                    cnt_next   = cnt_inc;
                    phase_next = PH_DIGITS;
                end
            end else begin
                emit = 1'b1;
            end
        end
        // A result returns the parser to its start state
        if (emit) begin
            phase_next = PH_SKIP;
            neg_next   = 1'b0;
            mag_next   = '0;
            cnt_next   = '0;
        end
    end

    // A token only waits when it must produce a beat and the slot is held
    assign pop_ready = !emit || !out_valid_reg || m_ready;
    assign do_pop    = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SKIP;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (do_pop) begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                mag_reg   <= mag_next;
                cnt_reg   <= cnt_next;
            end
            if (do_pop && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (do_pop && emit) begin
            out_value_reg  <= neg_reg ? signed'(32'd0 - mag_reg) : signed'(mag_reg);
            out_offset_reg <= cnt_wide[dtp_pkg::OFFSET_W-1:0];
            out_ovf_reg    <= ovf;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_parsed_value  = out_value_reg;
    assign m_end_offset    = out_offset_reg;
    assign m_overflow_stop = out_ovf_reg;

    // Start state carries no partial number
    a_skip_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SKIP) |-> (mag_reg == '0 && !neg_reg))
        else $error("parser in skip phase with non-zero magnitude or sign");

    // Magnitude never leaves the signed 32-bit range for its sign
    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mag_reg <= (neg_reg ? dtp_pkg::NEG_LIMIT : dtp_pkg::POS_LIMIT))
        else $error("magnitude beyond its limit");

    // Byte count saturates
    a_cnt_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_MAX)
        else $error("byte count above saturation point");

    // A stopping token always lands a result beat
    a_emit_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && emit) |=> (out_valid_reg && out_ovf_reg == $past(ovf)))
        else $error("stopping token did not produce a result beat");

endmodule

[sv/decimal_text_to_int32_parser.sv]
// ----------------------------------------------------------------------------
// Decimal text to int32 parser
// Parses a byte stream of decimal text into signed 32-bit results.
// ----------------------------------------------------------------------------
// Input channel s_*: one text byte per beat. Leading whitespace is skipped,
// one optional sign is taken, then digits are gathered. The first non-digit
// byte, or a digit that would overflow the signed 32-bit range, stops the
// parse; that byte is dropped and one result beat goes out on m_*:
// m_parsed_value, m_end_offset (bytes consumed before the stopping byte,
// saturating at 4095) and m_overflow_stop. All other bytes give no beat.
// Throughput: one byte per cycle sustained while no result beat is held back
// by m_ready; the back end does one multiply-by-ten and add per cycle on
// the running magnitude. A stopping byte passes through the front classify
// register and the token queue; the back end loads its output register as
// it pops the token.
// Reset (aresetn low, synchronous) empties the pipeline and returns the
// parser to its whitespace-skipping start state.
// When m_ready is low the result register holds its beat; the back end
// keeps consuming bytes that give no result, and the queue and front
// stage fill up before s_ready drops.
// ----------------------------------------------------------------------------
module decimal_text_to_int32_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_text_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_parsed_value,
    output logic [dtp_pkg::OFFSET_W-1:0]  m_end_offset,
    output logic                          m_overflow_stop
);

    logic          push_valid, push_ready;
    dtp_pkg::tok_t push_tok;
    logic          pop_valid, pop_ready;
    dtp_pkg::tok_t pop_tok;

    dtp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_tok    (push_tok)
    );

    dtp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_tok   (push_tok),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_tok    (pop_tok)
    );

    dtp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_tok         (pop_tok),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_parsed_value  (m_parsed_value),
        .m_end_offset    (m_end_offset),
        .m_overflow_stop (m_overflow_stop)
    );

endmodule

[test/decimal_text_to_int32_parser_test.sv]
// ----------------------------------------------------------------------------
// Decimal text to int32 parser testbench
// Sends text bytes into the parser, with random gaps on the input side and
// random back-pressure on the result side. A cycle-free model of the parser
// runs next to it and predicts every result beat. Each result beat is checked
// field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module decimal_text_to_int32_parser_test;

    // Parser phase as tracked by the model
    typedef enum logic {
        PH_SKIP,
        PH_DIGITS
    } parse_phase_t;

    typedef struct packed {
        logic signed [31:0]            value;
        logic [dtp_pkg::OFFSET_W-1:0]  offset;
        logic                          overflow;
    } parse_result_t;

    logic                          aclk;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [7:0]                    s_text_byte = 8'h00;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [31:0]            m_parsed_value;
    logic [dtp_pkg::OFFSET_W-1:0]  m_end_offset;
    logic                          m_overflow_stop;

    // Model state
    parse_phase_t                  model_phase = PH_SKIP;
    logic                          model_negative = 1'b0;
    logic [31:0]                   model_magnitude = '0;
    logic [dtp_pkg::OFFSET_W-1:0]  model_count = '0;

    parse_result_t                 expected_results[$];
    int                            mismatch_count = 0;
    int                            bytes_sent = 0;
    int                            idle_pct = 0;
    int                            ready_stall_left = 0;

    decimal_text_to_int32_parser DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_byte     (s_text_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_parsed_value  (m_parsed_value),
        .m_end_offset    (m_end_offset),
        .m_overflow_stop (m_overflow_stop)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Safety net: generous upper bound on run time
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Saturating byte counter of the model
    function automatic void bump_count();
        if (model_count < dtp_pkg::MAX_OFFSET)
            model_count++;
    endfunction

    // Advance the model by one byte; returns 1 when the byte stops a parse
    function automatic bit parse_text_byte(input logic [7:0] c, output parse_result_t r);
        logic [31:0] digit;
        logic [31:0] limit;
        logic        ovf;
        ovf = 1'b0;
        r   = '0;
        if (model_phase != PH_DIGITS) begin
            if (c inside {dtp_pkg::CH_SPACE, dtp_pkg::CH_LF, dtp_pkg::CH_TAB,
                          dtp_pkg::CH_VT, dtp_pkg::CH_FF, dtp_pkg::CH_CR}) begin
                bump_count();
                return 1'b0;
            end
            if (c == dtp_pkg::CH_MINUS || c == dtp_pkg::CH_PLUS) begin
                model_negative = (c == dtp_pkg::CH_MINUS);
                model_phase    = PH_DIGITS;
                bump_count();
                return 1'b0;
            end
            // digit or stopper straight from the skip phase
            model_phase = PH_DIGITS;
        end
        if (c >= dtp_pkg::CH_ZERO && c <= dtp_pkg::CH_NINE) begin
            digit = 32'(c - dtp_pkg::CH_ZERO);
            limit = model_negative ? dtp_pkg::NEG_LIMIT : dtp_pkg::POS_LIMIT;
            if (model_magnitude > (limit - digit) / 32'd10) begin
                ovf = 1'b1;
            end else begin
                model_magnitude = model_magnitude * 32'd10 + digit;
                bump_count();
                return 1'b0;
            end
        end
        r.value    = model_negative ? (32'd0 - model_magnitude) : model_magnitude;
        r.offset   = model_count;
        r.overflow = ovf;
        model_phase     = PH_SKIP;
        model_negative  = 1'b0;
        model_magnitude = '0;
        model_count     = '0;
        return 1'b1;
    endfunction

    // One input beat, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b);
        int            gap;
        parse_result_t r;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 16);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_text_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (parse_text_byte(b, r))
            expected_results.push_back(r);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_decimal(input longint unsigned mag);
        logic [7:0]        digits[$];
        longint unsigned   rest;
        rest = mag;
        do begin
            digits.push_front(8'(dtp_pkg::CH_ZERO + rest % 10));
            rest = rest / 10;
        end while (rest != 0);
        foreach (digits[i])
            send_byte(digits[i]);
    endtask

    // Result side back-pressure, in bursts
    always @(negedge aclk) begin
        if (ready_stall_left > 0) begin
            m_ready <= 1'b0;
            ready_stall_left--;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
            ready_stall_left = $urandom_range(1, 16) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge aclk) begin
        parse_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected beat value=%0d offset=%0d ovf=%0b",
                                          m_parsed_value, m_end_offset, m_overflow_stop));
            end else begin
                e = expected_results.pop_front();
                if (m_parsed_value !== e.value)
                    report_mismatch($sformatf("parsed_value %0d, expected %0d",
                                              m_parsed_value, e.value));
                if (m_end_offset !== e.offset)
                    report_mismatch($sformatf("end_offset %0d, expected %0d",
                                              m_end_offset, e.offset));
                if (m_overflow_stop !== e.overflow)
                    report_mismatch($sformatf("overflow_stop %0b, expected %0b",
                                              m_overflow_stop, e.overflow));
            end
        end
    end

    // Plain numbers, both signs, extreme stopping bytes
    task automatic test_basic_numbers();
        send_text("0");
        send_byte(8'h00);
        send_text("42x");
        send_text("-907");
        send_byte(8'hFF);
        send_text("+0015 ");
    endtask

    // Every whitespace code, lone signs, empty string, digit with no sign
    task automatic test_whitespace_and_signs();
        send_byte(dtp_pkg::CH_SPACE);
        send_byte(dtp_pkg::CH_LF);
        send_byte(dtp_pkg::CH_TAB);
        send_byte(dtp_pkg::CH_VT);
        send_byte(dtp_pkg::CH_FF);
        send_byte(dtp_pkg::CH_CR);
        send_byte(dtp_pkg::CH_MINUS);
        send_byte(8'hFF);
        send_text("+-");
        send_byte(8'h00);
        send_text("7+");
    endtask

    // Both magnitude limits, exact and one past
    task automatic test_overflow_limits();
        send_decimal(64'd2147483647);
        send_byte(dtp_pkg::CH_SPACE);
        send_decimal(64'd2147483648);
        send_byte(8'h00);
        send_byte(dtp_pkg::CH_MINUS);
        send_decimal(64'd2147483648);
        send_byte(dtp_pkg::CH_CR);
        send_byte(dtp_pkg::CH_MINUS);
        send_decimal(64'd2147483649);
        send_byte(8'h00);
        send_byte(dtp_pkg::CH_PLUS);
        send_decimal(64'd21474836470);
        send_text("q");
    endtask

    // Offset counter saturates in the skip phase and stays there through
    // the sign and the digits
    task automatic test_offset_saturation();
        repeat (dtp_pkg::MAX_OFFSET + 5)
            send_byte(dtp_pkg::CH_SPACE);
        send_byte(dtp_pkg::CH_MINUS);
        send_text("93");
        send_byte(8'hFF);
    endtask

    // Mostly well-formed numbers with random content, some noise
    task automatic test_random_text(input int n_bytes);
        int               start;
        longint unsigned  mag;
        logic [7:0]       b;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            // change idling density now and then; none over the last part
            if ((bytes_sent - start) % 200 < 12) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 12;
                    default: idle_pct = 45;
                endcase
            end
            if (bytes_sent - start > n_bytes - 300)
                idle_pct = 0;

            if ($urandom_range(0, 4) == 0) begin
                // noise bytes
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(0, 3)) begin
                    case ($urandom_range(0, 5))
                        0: send_byte(dtp_pkg::CH_SPACE);
                        1: send_byte(dtp_pkg::CH_LF);
                        2: send_byte(dtp_pkg::CH_TAB);
                        3: send_byte(dtp_pkg::CH_VT);
                        4: send_byte(dtp_pkg::CH_FF);
                        default: send_byte(dtp_pkg::CH_CR);
                    endcase
                end
                case ($urandom_range(0, 2))
                    0: send_byte(dtp_pkg::CH_MINUS);
                    1: send_byte(dtp_pkg::CH_PLUS);
                    default: ;
                endcase
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 3))
                        send_byte(dtp_pkg::CH_ZERO);
                case ($urandom_range(0, 3))
                    0: mag = $urandom_range(0, 999);
                    1: mag = $urandom;
                    2: mag = 64'd2147483648 + $urandom_range(0, 40) - 20;
                    default: mag = {$urandom, $urandom} % 64'd100_000_000_000;
                endcase
                send_decimal(mag);
                // any non-digit stops the number
                do b = 8'($urandom_range(0, 255));
                while (b >= dtp_pkg::CH_ZERO && b <= dtp_pkg::CH_NINE);
                send_byte(b);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        idle_pct = 0;
        test_basic_numbers();
        idle_pct = 20;
        test_whitespace_and_signs();
        test_overflow_limits();
        idle_pct = 5;
        test_offset_saturation();
        test_random_text(1950);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
sv/dtp_pkg.sv
sv/dtp_front.sv
sv/dtp_queue.sv
sv/dtp_back.sv
sv/decimal_text_to_int32_parser.sv
test/decimal_text_to_int32_parser_test.sv
